// ===== rtl/mtog_pkg.sv =====
// Shared types, codes and helpers for the mip tile offset generator.
// Used by every module of the block; depends on nothing.
`default_nettype none
package mtog_pkg;

  localparam int unsigned TILE_PADDING_DEFAULT = 20;
  localparam int unsigned IN_TDATA_W           = 8;
  localparam int unsigned OUT_TDATA_W          = 208;
  localparam int unsigned CFG_ADDR_W           = 5;
  localparam int unsigned DIV_N_W              = 16;
  localparam int unsigned DIV_D_W              = 13;
  localparam int unsigned DIV_CNT_W            = 5;
  localparam int unsigned MUL_A_W              = 26;
  localparam int unsigned MUL_B_W              = 16;
  localparam int unsigned MUL_P_W              = MUL_A_W + MUL_B_W;
  localparam logic [12:0] TILE_DIM_MAX         = 13'd4096;
  localparam logic [4:0]  LEVELS_MAX           = 5'd16;

  typedef enum logic [2:0] {
    REG_FULL_WIDTH    = 3'd0,
    REG_FULL_HEIGHT   = 3'd1,
    REG_TILE_WIDTH    = 3'd2,
    REG_TILE_HEIGHT   = 3'd3,
    REG_MIP_LEVELS    = 3'd4,
    REG_PIXEL_SIZE    = 3'd5,
    REG_CUSTOM_LAYOUT = 3'd6,
    REG_FORCE_DESC    = 3'd7
  } reg_idx_t;

  typedef enum logic [1:0] {
    KIND_HDR  = 2'd0,
    KIND_TILE = 2'd1,
    KIND_DONE = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_TILE   = 2'd1,
    PH_DONE   = 2'd2
  } phase_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_DIV_X,
    S_DIV_Y,
    S_MUL_T,
    S_MUL_E,
    S_HDR,
    S_MUL_WH,
    S_MUL_PS,
    S_TILE,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic               start;
    logic [DIV_N_W-1:0] dividend;
    logic [DIV_D_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [DIV_N_W-1:0] quot;
    logic [DIV_D_W-1:0] rem;
  } div_rsp_t;

  typedef struct packed {
    kind_t       kind;
    logic [3:0]  mip_level;
    logic [31:0] tile_index;
    logic [12:0] tile_w;
    logic [12:0] tile_h;
    logic [47:0] file_offset;
    logic [31:0] offset_in_mip;
    logic        desc_valid;
    logic [31:0] tiles_reported;
    logic [31:0] tiles_following;
    logic        last;
  } res_t;

  function automatic logic [12:0] eff_dim(input logic [12:0] v);
    logic [12:0] r;
    if (v == 13'd0) r = 13'd1;
    else if (v > TILE_DIM_MAX) r = TILE_DIM_MAX;
    else r = v;
    return r;
  endfunction

  function automatic logic [4:0] eff_levels(input logic [4:0] v);
    return (v > LEVELS_MAX) ? LEVELS_MAX : v;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/mtog_div.sv =====
// Iterative restoring divider, one quotient bit per cycle.
// Shared by the X and Y tile count steps; depends on mtog_pkg.
`default_nettype none
module mtog_div (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire mtog_pkg::div_req_t req,
  output mtog_pkg::div_rsp_t      rsp
);
  import mtog_pkg::*;

  logic [DIV_N_W-1:0]   quo_r, quo_nxt;
  logic [DIV_D_W-1:0]   rem_r, rem_nxt;
  logic [DIV_D_W-1:0]   dvs_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 busy_r, done_r;
  logic [DIV_D_W:0]     trial;

  always_comb begin
    trial = {rem_r, quo_r[DIV_N_W-1]};
    if (trial >= {1'b0, dvs_r}) begin
      rem_nxt = DIV_D_W'(trial - {1'b0, dvs_r});
      quo_nxt = {quo_r[DIV_N_W-2:0], 1'b1};
    end else begin
      rem_nxt = trial[DIV_D_W-1:0];
      quo_nxt = {quo_r[DIV_N_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == DIV_CNT_W'(1));
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= DIV_CNT_W'(DIV_N_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - DIV_CNT_W'(1);
        if (cnt_r == DIV_CNT_W'(1)) busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo_r <= req.dividend;
      rem_r <= '0;
      dvs_r <= req.divisor;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = quo_r;
  assign rsp.rem  = rem_r;

endmodule
`default_nettype wire

// ===== rtl/mtog_mul.sv =====
// Registered multiplier shared by tile counts, edge threshold and tile byte size.
// Depends on mtog_pkg.
`default_nettype none
module mtog_mul (
  input  wire logic                          clk,
  input  wire logic [mtog_pkg::MUL_A_W-1:0]  a,
  input  wire logic [mtog_pkg::MUL_B_W-1:0]  b,
  output logic      [mtog_pkg::MUL_P_W-1:0]  p
);
  import mtog_pkg::*;

  logic [MUL_P_W-1:0] p_r;

  always_ff @(posedge clk) begin
    p_r <= MUL_P_W'(a) * MUL_P_W'(b);
  end

  assign p = p_r;

endmodule
`default_nettype wire

// ===== rtl/mip_tile_offset_generator_unit.sv =====
// Top level of the mip tile offset generator: config registers, sequencer, output word.
// Instantiates mtog_div and mtog_mul; depends on mtog_pkg.
//
// Each accepted input word yields one output word. A level header runs the shared
// divider for X and then for Y (16 steps each), then makes two passes through the
// shared multiplier. A tile record makes two passes through the multiplier (width
// times height, then bytes per pixel). A finished record goes straight from the start
// state to the emit state. The block takes one word at a time; the result sits in an
// output register, so the next word is taken while that result waits.
`default_nettype none
module mip_tile_offset_generator_unit #(
  parameter int unsigned TILE_PADDING_BYTES = mtog_pkg::TILE_PADDING_DEFAULT
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // in_tdata: [0] restart
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  input  wire logic [mtog_pkg::IN_TDATA_W-1:0]     in_tdata,
  // out_tdata: mip_level, tile_index, tile_w, tile_h, file_offset, offset_in_mip,
  //            desc_valid, tiles_reported, tiles_following
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  output logic [mtog_pkg::OUT_TDATA_W-1:0]         out_tdata,
  // out_tuser: kind
  output logic [1:0]                               out_tuser,
  output logic                                     out_tlast,
  input  wire logic                                cfg_psel,
  input  wire logic                                cfg_penable,
  input  wire logic                                cfg_pwrite,
  input  wire logic [mtog_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  wire logic [31:0]                         cfg_pwdata,
  output logic [31:0]                              cfg_prdata,
  output logic                                     cfg_pready
);
  import mtog_pkg::*;

  localparam logic [47:0] PAD = 48'(TILE_PADDING_BYTES);

  // config registers
  logic [15:0] full_width_r, full_height_r;
  logic [12:0] tile_width_r, tile_height_r;
  logic [4:0]  mip_levels_r;
  logic [7:0]  pixel_size_r;
  logic        custom_layout_r, force_desc_r;
  logic        cfg_wr;
  reg_idx_t    cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[4:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_width_r    <= 16'd1024;
      full_height_r   <= 16'd1024;
      tile_width_r    <= 13'd256;
      tile_height_r   <= 13'd256;
      mip_levels_r    <= 5'd1;
      pixel_size_r    <= 8'd8;
      custom_layout_r <= 1'b0;
      force_desc_r    <= 1'b1;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_FULL_WIDTH:    full_width_r    <= cfg_pwdata[15:0];
        REG_FULL_HEIGHT:   full_height_r   <= cfg_pwdata[15:0];
        REG_TILE_WIDTH:    tile_width_r    <= cfg_pwdata[12:0];
        REG_TILE_HEIGHT:   tile_height_r   <= cfg_pwdata[12:0];
        REG_MIP_LEVELS:    mip_levels_r    <= cfg_pwdata[4:0];
        REG_PIXEL_SIZE:    pixel_size_r    <= cfg_pwdata[7:0];
        REG_CUSTOM_LAYOUT: custom_layout_r <= cfg_pwdata[0];
        REG_FORCE_DESC:    force_desc_r    <= cfg_pwdata[0];
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_FULL_WIDTH:    cfg_prdata = 32'(full_width_r);
      REG_FULL_HEIGHT:   cfg_prdata = 32'(full_height_r);
      REG_TILE_WIDTH:    cfg_prdata = 32'(tile_width_r);
      REG_TILE_HEIGHT:   cfg_prdata = 32'(tile_height_r);
      REG_MIP_LEVELS:    cfg_prdata = 32'(mip_levels_r);
      REG_PIXEL_SIZE:    cfg_prdata = 32'(pixel_size_r);
      REG_CUSTOM_LAYOUT: cfg_prdata = 32'(custom_layout_r);
      REG_FORCE_DESC:    cfg_prdata = 32'(force_desc_r);
    endcase
  end

  // walk state
  state_t      state_r, state_nxt;
  phase_t      phase_r;
  logic [4:0]  level_r;
  logic [31:0] tile_r;
  logic [15:0] col_r;
  logic [15:0] txp_r, tyc_r;
  logic [11:0] edge_w_r, edge_h_r;
  logic        edge_x_r, edge_y_r;
  logic [31:0] lt_r, thr_r;
  logic [47:0] pos_r, lstart_r;
  logic        desc_r;
  logic [12:0] w_r, h_r;
  res_t        res_r, res_nxt, out_res_r;
  logic        out_valid_r;

  // shared units
  div_req_t           div_req;
  div_rsp_t           div_rsp;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [MUL_P_W-1:0] mul_p;

  mtog_div u_div (.clk(clk), .rst_n(rst_n), .req(div_req), .rsp(div_rsp));
  mtog_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(mul_p));

  logic [12:0] tw_e, th_e, w_sel, h_sel;
  logic [4:0]  lv_e;
  logic [15:0] mw, mh, typ;
  logic        walk_end, hdr_desc, final_level, tile_wrap, out_free;
  logic [31:0] hdr_follow;
  logic [47:0] hdr_pos, tile_pos;
  logic [32:0] tile_inc;
  logic [16:0] col_inc;

  always_comb begin
    tw_e        = eff_dim(tile_width_r);
    th_e        = eff_dim(tile_height_r);
    lv_e        = eff_levels(mip_levels_r);
    mw          = full_width_r >> level_r;
    mh          = full_height_r >> level_r;
    typ         = tyc_r + 16'(edge_y_r);
    walk_end    = (phase_r == PH_DONE) || (phase_r == PH_HEADER && level_r >= lv_e);
    hdr_desc    = edge_x_r || edge_y_r || force_desc_r;
    hdr_follow  = (!custom_layout_r && !hdr_desc) ? 32'd0 : lt_r;
    hdr_pos     = custom_layout_r ? pos_r + PAD : pos_r;
    col_inc     = {1'b0, col_r} + 17'd1;
    tile_inc    = {1'b0, tile_r} + 33'd1;
    w_sel       = (edge_x_r && col_inc == {1'b0, txp_r}) ? {1'b0, edge_w_r} : tw_e;
    h_sel       = (edge_y_r && tile_r >= thr_r) ? {1'b0, edge_h_r} : th_e;
    final_level = ({1'b0, level_r} + 6'd1) >= {1'b0, lv_e};
    tile_pos    = pos_r + 48'(mul_p[33:0]) + (custom_layout_r ? 48'd0 : PAD);
    tile_wrap   = tile_inc >= {1'b0, lt_r};
    out_free    = !out_valid_r || out_tready;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (in_tvalid) state_nxt = S_START;
      S_START: begin
        if (walk_end) state_nxt = S_EMIT;
        else if (phase_r == PH_TILE) state_nxt = S_MUL_WH;
        else state_nxt = S_DIV_X;
      end
      S_DIV_X:  if (div_rsp.done) state_nxt = S_DIV_Y;
      S_DIV_Y:  if (div_rsp.done) state_nxt = S_MUL_T;
      S_MUL_T:  state_nxt = S_MUL_E;
      S_MUL_E:  state_nxt = S_HDR;
      S_HDR:    state_nxt = S_EMIT;
      S_MUL_WH: state_nxt = S_MUL_PS;
      S_MUL_PS: state_nxt = S_TILE;
      S_TILE:   state_nxt = S_EMIT;
      S_EMIT:   if (out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_tready        = (state_r == S_IDLE);
    div_req.start    = (state_r == S_START && !walk_end && phase_r == PH_HEADER) ||
                       (state_r == S_DIV_X && div_rsp.done);
    div_req.dividend = (state_r == S_START) ? mw : mh;
    div_req.divisor  = (state_r == S_START) ? tw_e : th_e;
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_MUL_T: begin
        mul_a = MUL_A_W'(txp_r);
        mul_b = typ;
      end
      S_MUL_E: begin
        mul_a = MUL_A_W'(txp_r);
        mul_b = tyc_r;
      end
      S_MUL_WH: begin
        mul_a = MUL_A_W'(w_sel);
        mul_b = MUL_B_W'(h_sel);
      end
      S_MUL_PS: begin
        mul_a = mul_p[MUL_A_W-1:0];
        mul_b = MUL_B_W'(pixel_size_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= PH_HEADER;
      level_r     <= '0;
      tile_r      <= '0;
      col_r       <= '0;
      txp_r       <= '0;
      tyc_r       <= '0;
      edge_w_r    <= '0;
      edge_h_r    <= '0;
      edge_x_r    <= 1'b0;
      edge_y_r    <= 1'b0;
      lt_r        <= '0;
      thr_r       <= '0;
      pos_r       <= '0;
      lstart_r    <= '0;
      desc_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_EMIT && out_free) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid && in_tdata[0]) begin
            level_r  <= '0;
            tile_r   <= '0;
            col_r    <= '0;
            pos_r    <= '0;
            lstart_r <= '0;
            phase_r  <= PH_HEADER;
            desc_r   <= 1'b0;
          end
        end
        S_START: if (walk_end) phase_r <= PH_DONE;
        S_DIV_X: begin
          if (div_rsp.done) begin
            txp_r    <= div_rsp.quot + 16'(div_rsp.rem != '0);
            edge_x_r <= (div_rsp.rem != '0);
            edge_w_r <= div_rsp.rem[11:0];
          end
        end
        S_DIV_Y: begin
          if (div_rsp.done) begin
            tyc_r    <= div_rsp.quot;
            edge_y_r <= (div_rsp.rem != '0);
            edge_h_r <= div_rsp.rem[11:0];
          end
        end
        S_MUL_E: lt_r <= mul_p[31:0];
        S_HDR: begin
          thr_r    <= mul_p[31:0];
          desc_r   <= hdr_desc;
          pos_r    <= hdr_pos;
          lstart_r <= hdr_pos;
          tile_r   <= '0;
          col_r    <= '0;
          if (hdr_follow == 32'd0) level_r <= level_r + 5'd1;
          else phase_r <= PH_TILE;
        end
        S_MUL_WH: begin
          w_r <= w_sel;
          h_r <= h_sel;
        end
        S_TILE: begin
          pos_r <= tile_pos;
          if (tile_wrap) begin
            level_r <= level_r + 5'd1;
            tile_r  <= '0;
            col_r   <= '0;
            phase_r <= PH_HEADER;
          end else begin
            tile_r <= tile_inc[31:0];
            col_r  <= (col_inc >= {1'b0, txp_r}) ? 16'd0 : col_inc[15:0];
          end
        end
        default: ;
      endcase
    end
  end

  // result staging and output word
  always_comb begin
    res_nxt = res_r;
    unique case (state_r)
      S_START: begin
        if (walk_end) begin
          res_nxt             = '0;
          res_nxt.kind        = KIND_DONE;
          res_nxt.file_offset = pos_r;
        end
      end
      S_HDR: begin
        res_nxt                 = '0;
        res_nxt.kind            = KIND_HDR;
        res_nxt.mip_level       = level_r[3:0];
        res_nxt.file_offset     = hdr_pos;
        res_nxt.desc_valid      = hdr_desc;
        res_nxt.tiles_reported  = custom_layout_r ? 32'd1 : lt_r;
        res_nxt.tiles_following = hdr_follow;
      end
      S_TILE: begin
        res_nxt                 = '0;
        res_nxt.kind            = KIND_TILE;
        res_nxt.mip_level       = level_r[3:0];
        res_nxt.tile_index      = tile_r;
        res_nxt.tile_w          = w_r;
        res_nxt.tile_h          = h_r;
        res_nxt.file_offset     = pos_r;
        res_nxt.offset_in_mip   = 32'(pos_r - lstart_r);
        res_nxt.desc_valid      = desc_r;
        res_nxt.last            = final_level && (tile_inc == {1'b0, lt_r});
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    if (state_r == S_EMIT && out_free) out_res_r <= res_r;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.kind;
  assign out_tlast  = out_res_r.last;
  assign out_tdata  = {1'b0, out_res_r.tiles_following, out_res_r.tiles_reported,
                       out_res_r.desc_valid, out_res_r.offset_in_mip,
                       out_res_r.file_offset, out_res_r.tile_h, out_res_r.tile_w,
                       out_res_r.tile_index, out_res_r.mip_level};

endmodule
`default_nettype wire

// ===== rtl/mtog_chk.sv =====
// Port-level checker for mip_tile_offset_generator_unit, bound to the top level.
// Depends on mtog_pkg.
`default_nettype none
module mtog_chk (
  input wire logic                               clk,
  input wire logic                               rst_n,
  input wire logic                               in_tvalid,
  input wire logic                               in_tready,
  input wire logic                               out_tvalid,
  input wire logic                               out_tready,
  input wire logic [mtog_pkg::OUT_TDATA_W-1:0]   out_tdata,
  input wire logic [1:0]                         out_tuser,
  input wire logic                               out_tlast
);
  import mtog_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
      $stable(out_tuser) && $stable(out_tlast))
    else $error("output word changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken again while a word is in work");

  a_last_on_tile: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tuser == KIND_TILE)
    else $error("last set on a non-tile word");

  a_hdr_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_HDR |->
      out_tdata[61:4] == '0 && out_tdata[141:110] == '0)
    else $error("header word carries tile fields");

  a_done_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_DONE |->
      out_tdata[61:0] == '0 && out_tdata[207:110] == '0 && !out_tlast)
    else $error("finished word carries fields other than the offset");

endmodule

bind mip_tile_offset_generator_unit mtog_chk u_mtog_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
`default_nettype wire
